FILE: rtl/core/cpio_newc_archive_walker_defines.svh
// Assertion macros shared by the cpio walker checker
`ifndef CPIO_NEWC_ARCHIVE_WALKER_DEFINES_SVH
`define CPIO_NEWC_ARCHIVE_WALKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CPIO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CPIO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cpio_pkg.sv
// Package for the cpio newc walker: types, constants and decode helpers
package cpio_pkg;

	// header layout
	localparam int unsigned HEADER_LEN  = 110;
	localparam int unsigned FSIZE_FIRST = 54;
	localparam int unsigned NSIZE_FIRST = 94;
	localparam int unsigned FIELD_LEN   = 8;
	localparam int unsigned TRAILER_LEN = 10;

	// address masking default
	localparam int unsigned ADDRESS_BITS_DEF = 32;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_ARCHIVE_BASE = 1'b0;

	// walk phases
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_NAME    = 3'd1,
		PH_NAMEPAD = 3'd2,
		PH_DATA    = 3'd3,
		PH_DATAPAD = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	// one result item
	typedef struct packed {
		logic [7:0]  name_byte;
		logic [31:0] name_index;
		logic        entry_done;
		logic [31:0] data_address;
		logic [31:0] file_size;
		logic [31:0] name_size;
		logic        is_trailer;
	} result_t;

	// shift in one hex character; anything outside 0-9 and A-F adds zero
	function automatic logic [31:0] hex_step(input logic [31:0] acc, input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		case (c) inside
			[8'h30:8'h39]: v = c[3:0];
			[8'h41:8'h46]: v = 4'(c - 8'h37);
			default:       v = 4'd0;
		endcase
		return {acc[27:0], v};
	endfunction

	// the text "TRAILER!!!"
	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h54;
			4'd1:    ch = 8'h52;
			4'd2:    ch = 8'h41;
			4'd3:    ch = 8'h49;
			4'd4:    ch = 8'h4C;
			4'd5:    ch = 8'h45;
			4'd6:    ch = 8'h52;
			4'd7:    ch = 8'h21;
			4'd8:    ch = 8'h21;
			4'd9:    ch = 8'h21;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/core/cpio_step.sv
// Walk state and per-byte decode: header fields, name bytes, region skipping
module cpio_step #(
	parameter int unsigned ADDRESS_BITS = cpio_pkg::ADDRESS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        byte_s1,
	input  logic [31:0]       archive_base,
	output logic              res_valid,
	output cpio_pkg::result_t res
);

	localparam logic [31:0] AddrMask = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << ADDRESS_BITS) - 64'd1);

	typedef enum logic [2:0] {
		ENT_NONE, ENT_NAMEPAD, ENT_DATA, ENT_DATAPAD, ENT_HEADER
	} enter_t;

	cpio_pkg::phase_t phase_q, phase_d;
	logic [6:0]  hc_q, hc_d;
	logic [31:0] nsz_q, nsz_d;
	logic [31:0] fsz_q, fsz_d;
	logic [31:0] rc_q, rc_d;
	logic [31:0] off_q, off_d;
	logic        tm_q, tm_d;

	enter_t      enter;
	logic [1:0]  npad, fpad;
	logic        try_np, try_d, try_dp;
	logic        trailer;
	logic [31:0] data_off;

	// next state for one byte
	always_comb begin
		phase_d   = phase_q;
		hc_d      = hc_q;
		nsz_d     = nsz_q;
		fsz_d     = fsz_q;
		rc_d      = rc_q;
		off_d     = off_q;
		tm_d      = tm_q;
		enter     = ENT_NONE;
		res       = '0;
		res_valid = 1'b0;
		trailer   = 1'b0;
		data_off  = 32'((off_q + 32'd4) & ~32'd3);

		if (step_en && phase_q != cpio_pkg::PH_DONE) begin
			off_d = 32'(off_q + 32'd1);
			case (phase_q)
				cpio_pkg::PH_HEADER: begin
					if (hc_q inside {[cpio_pkg::FSIZE_FIRST:
						cpio_pkg::FSIZE_FIRST + cpio_pkg::FIELD_LEN - 1]})
						fsz_d = cpio_pkg::hex_step(fsz_q, byte_s1);
					if (hc_q inside {[cpio_pkg::NSIZE_FIRST:
						cpio_pkg::NSIZE_FIRST + cpio_pkg::FIELD_LEN - 1]})
						nsz_d = cpio_pkg::hex_step(nsz_q, byte_s1);
					hc_d = 7'(hc_q + 7'd1);
					if (hc_d >= 7'(cpio_pkg::HEADER_LEN)) begin
						if (nsz_d == 32'd0) begin
							enter = ENT_NAMEPAD;
						end else begin
							phase_d = cpio_pkg::PH_NAME;
							rc_d    = 32'd0;
						end
					end
				end
				cpio_pkg::PH_NAME: begin
					if (rc_q < 32'(cpio_pkg::TRAILER_LEN)
						&& byte_s1 != cpio_pkg::trailer_char(rc_q[3:0]))
						tm_d = 1'b0;
					res_valid      = 1'b1;
					res.name_byte  = byte_s1;
					res.name_index = rc_q;
					if (32'(rc_q + 32'd1) == nsz_q) begin
						trailer          = tm_d && nsz_q >= 32'(cpio_pkg::TRAILER_LEN);
						res.entry_done   = 1'b1;
						res.data_address = 32'(archive_base + data_off) & AddrMask;
						res.file_size    = fsz_q;
						res.name_size    = nsz_q;
						res.is_trailer   = trailer;
						if (trailer)
							phase_d = cpio_pkg::PH_DONE;
						else
							enter = ENT_NAMEPAD;
					end else begin
						rc_d = 32'(rc_q + 32'd1);
					end
				end
				cpio_pkg::PH_NAMEPAD, cpio_pkg::PH_DATA, cpio_pkg::PH_DATAPAD: begin
					rc_d = 32'(rc_q - 32'd1);
					if (rc_d == 32'd0) begin
						case (phase_q)
							cpio_pkg::PH_NAMEPAD: enter = ENT_DATA;
							cpio_pkg::PH_DATA:    enter = ENT_DATAPAD;
							default:              enter = ENT_HEADER;
						endcase
					end
				end
				default: ;
			endcase
		end

		// pick the first non-empty region from the entry point on
		npad   = 2'(2'd0 - (2'd2 + nsz_d[1:0]));
		fpad   = 2'(2'd0 - fsz_d[1:0]);
		try_np = enter == ENT_NAMEPAD;
		try_d  = try_np || enter == ENT_DATA;
		try_dp = try_d || enter == ENT_DATAPAD;
		if (try_np && npad != 2'd0) begin
			phase_d = cpio_pkg::PH_NAMEPAD;
			rc_d    = 32'(npad);
		end else if (try_d && fsz_d != 32'd0) begin
			phase_d = cpio_pkg::PH_DATA;
			rc_d    = fsz_d;
		end else if (try_dp && fpad != 2'd0) begin
			phase_d = cpio_pkg::PH_DATAPAD;
			rc_d    = 32'(fpad);
		end else if (enter != ENT_NONE) begin
			phase_d = cpio_pkg::PH_HEADER;
			hc_d    = 7'd0;
			nsz_d   = 32'd0;
			fsz_d   = 32'd0;
			rc_d    = 32'd0;
			tm_d    = 1'b1;
		end
	end

	// walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cpio_pkg::PH_HEADER;
			hc_q    <= 7'd0;
			nsz_q   <= 32'd0;
			fsz_q   <= 32'd0;
			rc_q    <= 32'd0;
			off_q   <= 32'd0;
			tm_q    <= 1'b1;
		end else begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			nsz_q   <= nsz_d;
			fsz_q   <= fsz_d;
			rc_q    <= rc_d;
			off_q   <= off_d;
			tm_q    <= tm_d;
		end
	end

endmodule

FILE: rtl/core/cpio_outreg.sv
// Result register: holds one finished item until the receiver takes it
module cpio_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cpio_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_valid,
	output cpio_pkg::result_t out_res
);

	logic out_valid_q;
	cpio_pkg::result_t res_q;

	// valid flag: refills or drains whenever the slot moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

FILE: rtl/core/cpio_newc_archive_walker.sv
// cpio newc archive walker: top level with input stage, walker and result register
//
// Archive bytes arrive on archive_byte with archive_valid/archive_stall; an item is
// taken at a clock edge where archive_valid is high and archive_stall is low.
// Each name byte leaves on the name_* channel (name_valid/name_stall) with its index;
// the last name byte of an entry also carries entry_done, data_address, file_size,
// name_size and is_trailer. Header, padding and data bytes give no output item.
// The input register holds each byte taken; the combinational walker step turns it
// into the result register. Throughput: one byte per cycle while the receiver does
// not stall. archive_base is written over the APB-style port where paddr[2] is low;
// the user must write it only while idle, as the block does not enforce this.
// Reset clears the walk to the start of a header, the stream offset to zero and
// archive_base to zero. After the trailer entry, bytes are still taken and dropped.
// When the receiver stalls, the result register holds its item and the input stage
// holds one more byte; archive_stall rises only when both are full.
module cpio_newc_archive_walker #(
	parameter int unsigned ADDRESS_BITS = cpio_pkg::ADDRESS_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// archive byte channel
	input  logic                            archive_valid,
	output logic                            archive_stall,
	input  logic [7:0]                      archive_byte,
	// name byte channel
	output logic                            name_valid,
	input  logic                            name_stall,
	output logic [7:0]                      name_byte,
	output logic [31:0]                     name_index,
	output logic                            entry_done,
	output logic [31:0]                     data_address,
	output logic [31:0]                     file_size,
	output logic [31:0]                     name_size,
	output logic                            is_trailer,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpio_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              adv;
	logic              step_en;
	logic              res_valid;
	logic [31:0]       base_q;
	cpio_pkg::result_t res;
	cpio_pkg::result_t out_res;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cpio_pkg::REG_ARCHIVE_BASE) ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == cpio_pkg::REG_ARCHIVE_BASE) begin
			base_q <= pwdata;
		end
	end

	// input stage moves when the result slot can take its item
	assign adv           = !name_valid || !name_stall;
	assign step_en       = valid_s1 && adv;
	assign archive_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!archive_stall) begin
			valid_s1 <= archive_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (archive_valid && !archive_stall) begin
			byte_s1 <= archive_byte;
		end
	end

	cpio_step #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.byte_s1      (byte_s1),
		.archive_base (base_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	cpio_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_stall (name_stall),
		.out_valid (name_valid),
		.out_res   (out_res)
	);

	// result fields
	assign name_byte    = out_res.name_byte;
	assign name_index   = out_res.name_index;
	assign entry_done   = out_res.entry_done;
	assign data_address = out_res.data_address;
	assign file_size    = out_res.file_size;
	assign name_size    = out_res.name_size;
	assign is_trailer   = out_res.is_trailer;

endmodule

FILE: rtl/core/cpio_walker_chk.sv
// Port-level checker for the cpio walker, bound to the top level
`include "cpio_newc_archive_walker_defines.svh"

module cpio_walker_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        name_valid,
	input logic        name_stall,
	input logic [31:0] name_index,
	input logic        entry_done,
	input logic [31:0] data_address,
	input logic [31:0] file_size,
	input logic [31:0] name_size,
	input logic        is_trailer
);

	// a stalled item stays offered
	`CPIO_ASSERT_NEXT(a_hold, name_valid && name_stall, name_valid, "name item dropped under stall")

	// record fields are zero on bytes that do not close an entry
	`CPIO_ASSERT_NOW(a_zero_rec, name_valid && !entry_done, data_address == 32'd0 && file_size == 32'd0 && name_size == 32'd0 && !is_trailer, "record fields set on inner name byte")

	// the closing byte sits at index name_size-1
	`CPIO_ASSERT_NOW(a_last_idx, name_valid && entry_done, 32'(name_index + 32'd1) == name_size, "entry closed at wrong name index")

	// a trailer is only flagged on a closing byte of a long enough name
	`CPIO_ASSERT_NOW(a_trailer, name_valid && is_trailer, entry_done && name_size >= 32'd10, "trailer flag without a complete name")

endmodule

bind cpio_newc_archive_walker cpio_walker_chk u_chk (.*);
